[src/nqi_pkg.sv]
// Shared types, stage schedule and arithmetic step functions for the normal-to-quaternion pipeline.
`timescale 1ns / 1ps

package nqi_pkg;

  localparam logic [1:0] REG_UP_IS_Y    = 2'd0;
  localparam logic [1:0] REG_NORMALS    = 2'd1;
  localparam logic [1:0] REG_SCALE_EN   = 2'd2;
  localparam logic [1:0] REG_SCALE_MUL  = 2'd3;
  localparam logic [14:0] SCALE_MUL_RESET = 15'd256;

  localparam logic [15:0] QONE = 16'd16384;

  localparam int SQ1_N  = 31;
  localparam int DIV1_N = 32;
  localparam int DIV2_N = 31;
  localparam int SQ2_N  = 16;
  localparam int SQ3_N  = 32;
  localparam int CDIV_N = 15;

  localparam int S_SQUARE = 1;
  localparam int S_NEAR   = 2;
  localparam int S_SQ1    = 3;
  localparam int S_A      = S_SQ1 + SQ1_N;
  localparam int S_DIV1   = S_A + 1;
  localparam int S_A2     = S_DIV1 + DIV1_N;
  localparam int S_DIV2   = S_A2 + 1;
  localparam int S_PP0    = S_DIV2 + DIV2_N;
  localparam int S_SQ2    = S_PP0 + 1;
  localparam int S_W      = S_SQ2 + SQ2_N;
  localparam int S_SQ3    = S_W + 1;
  localparam int S_NN     = S_SQ3 + SQ3_N;
  localparam int S_OVF    = S_NN + 1;
  localparam int S_CDIV   = S_OVF + 1;
  localparam int S_FIN    = S_CDIV + CDIV_N;
  localparam int NST      = S_FIN + 1;

  typedef struct packed {
    logic               vld;
    logic        [31:0] px;
    logic        [31:0] py;
    logic        [31:0] pz;
    logic        [30:0] sc;
    logic               scv;
    logic               ov;
    logic               gen;
    logic               opp;
    logic               upy;
    logic               neg;
    logic        [30:0] au;
    logic signed [16:0] ca;
    logic signed [16:0] cb;
    logic signed [16:0] u;
    logic        [31:0] p2;
    logic        [31:0] l2;
    logic        [63:0] sv;
    logic        [63:0] sr;
    logic        [63:0] dr;
    logic        [31:0] dq;
    logic        [32:0] dd;
    logic        [30:0] lq;
    logic        [32:0] a;
    logic        [46:0] pp0;
    logic        [47:0] pp1;
    logic        [15:0] q0;
    logic        [47:0] ra;
    logic        [47:0] rb;
    logic        [14:0] qa;
    logic        [14:0] qb;
    logic               oa;
    logic               ob;
    logic        [15:0] fw;
    logic        [15:0] fx;
    logic        [15:0] fy;
    logic        [15:0] fz;
  } item_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [63:0] rem;
    logic        q;
  } dv_t;

  function automatic logic [15:0] mag17(input logic signed [16:0] x);
    logic [16:0] t;
    t = x[16] ? 17'(-x) : 17'(x);
    return t[15:0];
  endfunction

  function automatic sq_t sqrt_step(input logic [63:0] v, input logic [63:0] r, input int sh);
    logic [63:0] b;
    logic [63:0] t;
    sq_t o;
    b = 64'd1 << sh;
    t = r + b;
    if (v >= t) begin
      o.v = v - t;
      o.r = (r >> 1) + b;
    end else begin
      o.v = v;
      o.r = r >> 1;
    end
    return o;
  endfunction

  function automatic dv_t div_step(input logic [63:0] rem, input logic [32:0] den, input int sh);
    logic [63:0] t;
    dv_t o;
    t = {31'd0, den} << sh;
    if (rem >= t) begin
      o.rem = rem - t;
      o.q = 1'b1;
    end else begin
      o.rem = rem;
      o.q = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [15:0] signed_part(input logic neg, input logic ovf,
                                              input logic [14:0] q);
    logic [15:0] m;
    m = (ovf || ({1'b0, q} > QONE)) ? QONE : {1'b0, q};
    return neg ? 16'(-m) : m;
  endfunction

  function automatic item_t stage_step(input int k, input item_t d);
    item_t o;
    sq_t s;
    dv_t v0;
    dv_t v1;
    logic [15:0] caa;
    logic [15:0] cba;
    logic [15:0] ua;
    logic [32:0] asel;
    logic [31:0] nn;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [16:0] wr;
    logic [15:0] xa;
    logic [15:0] xb;
    logic near;
    int j;
    o = d;
    j = 0;
    if (k == S_SQUARE) begin
      caa = mag17(d.ca);
      cba = mag17(d.cb);
      ua = mag17(d.u);
      o.p2 = 32'(caa) * 32'(caa) + 32'(cba) * 32'(cba);
      o.l2 = o.p2 + 32'(ua) * 32'(ua);
      o.au = {ua, 15'd0};
    end
    if (k == S_NEAR) begin
      lhs = 64'(d.p2[20:0]) * 64'd1000000000000;
      rhs = 64'(d.l2) * 64'd1999999;
      near = (d.au != '0) && (d.p2 < 32'h0020_0000) && (lhs < rhs);
      o.gen = d.ov && !near;
      o.opp = d.ov && near && d.neg;
      o.sv = {2'b00, d.l2, 30'd0};
      o.sr = '0;
    end
    if (k >= S_SQ1 && k < S_A) begin
      j = k - S_SQ1;
      s = sqrt_step(d.sv, d.sr, 60 - 2 * j);
      o.sv = s.v;
      o.sr = s.r;
    end
    if (k == S_A) begin
      o.lq = d.sr[30:0];
      o.a = 33'(d.sr[30:0]) + 33'(d.au);
      o.dd = o.a;
      o.dr = {2'b00, d.p2, 30'd0};
      o.dq = '0;
    end
    if (k >= S_DIV1 && k < S_A2) begin
      j = k - S_DIV1;
      v0 = div_step(d.dr, d.dd, DIV1_N - 1 - j);
      o.dr = v0.rem;
      o.dq = d.dq | (32'(v0.q) << (DIV1_N - 1 - j));
    end
    if (k == S_A2) begin
      asel = d.neg ? {1'b0, d.dq} : d.a;
      if (asel == '0) begin
        asel = 33'd1;
      end
      o.a = asel;
      o.dr = {2'b00, asel, 29'd0};
      o.dd = {2'b00, d.lq};
      o.dq = '0;
    end
    if (k >= S_DIV2 && k < S_PP0) begin
      j = k - S_DIV2;
      v0 = div_step(d.dr, d.dd, DIV2_N - 1 - j);
      o.dr = v0.rem;
      o.dq = d.dq | (32'(v0.q) << (DIV2_N - 1 - j));
    end
    if (k == S_PP0) begin
      o.sv = {32'd0, d.dq};
      o.sr = '0;
      o.pp0 = 47'(d.lq) * 47'(d.a[15:0]);
    end
    if (k == S_SQ2) begin
      o.pp1 = 48'(d.lq) * 48'(d.a[32:16]);
    end
    if (k >= S_SQ2 && k < S_W) begin
      j = k - S_SQ2;
      s = sqrt_step(d.sv, d.sr, 30 - 2 * j);
      o.sv = s.v;
      o.sr = s.r;
    end
    if (k == S_W) begin
      wr = d.sr[16:0] + 17'd1;
      o.q0 = (wr[16:1] > QONE) ? QONE : wr[16:1];
      lhs = 64'(d.pp0) + (64'(d.pp1) << 16);
      o.sv = lhs << 1;
      o.sr = '0;
    end
    if (k >= S_SQ3 && k < S_NN) begin
      j = k - S_SQ3;
      s = sqrt_step(d.sv, d.sr, 62 - 2 * j);
      o.sv = s.v;
      o.sr = s.r;
    end
    if (k == S_NN) begin
      nn = d.sr[31:0];
      if (nn == '0) begin
        nn = 32'd1;
      end
      o.dd = {nn, 1'b0};
      o.ra = 48'({mag17(d.ca), 30'd0}) + 48'(nn);
      o.rb = 48'({mag17(d.cb), 30'd0}) + 48'(nn);
    end
    if (k == S_OVF) begin
      o.oa = 64'(d.ra) >= (64'(d.dd) << CDIV_N);
      o.ob = 64'(d.rb) >= (64'(d.dd) << CDIV_N);
      o.qa = '0;
      o.qb = '0;
    end
    if (k >= S_CDIV && k < S_FIN) begin
      j = k - S_CDIV;
      v0 = div_step({16'd0, d.ra}, d.dd, CDIV_N - 1 - j);
      v1 = div_step({16'd0, d.rb}, d.dd, CDIV_N - 1 - j);
      o.ra = v0.rem[47:0];
      o.rb = v1.rem[47:0];
      o.qa = d.qa | (15'(v0.q) << (CDIV_N - 1 - j));
      o.qb = d.qb | (15'(v1.q) << (CDIV_N - 1 - j));
    end
    if (k == S_FIN) begin
      xa = signed_part(d.ca[16], d.oa, d.qa);
      xb = signed_part(d.cb[16], d.ob, d.qb);
      if (d.gen) begin
        o.fw = d.q0;
        o.fx = xa;
        o.fy = d.upy ? 16'd0 : xb;
        o.fz = d.upy ? xb : 16'd0;
      end else if (d.opp) begin
        o.fw = 16'd0;
        o.fx = QONE;
        o.fy = 16'd0;
        o.fz = 16'd0;
      end else begin
        o.fw = QONE;
        o.fx = 16'd0;
        o.fy = 16'd0;
        o.fz = 16'd0;
      end
    end
    return o;
  endfunction

endpackage

[src/normal_to_quaternion_instancer.sv]
// Each input transfer moves through the stage registers until its result is held in the output register.
// Throughput: one point per cycle unless the output stalls; every square root and divide is unrolled one bit per stage.
// The longest chain is the three square roots and three divides in series along the pipeline.
// A stalled output with a valid result freezes the whole pipeline; nothing is lost or repeated.
// Reset clears every stage valid bit and loads the configuration reset values.
`timescale 1ns / 1ps

module normal_to_quaternion_instancer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [14:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic        [15:0] width,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic               orientation_valid,
  output logic        [30:0] scale_out,
  output logic               scale_valid
);
  import nqi_pkg::*;

  logic        up_is_y;
  logic        normals_present;
  logic        scale_enable;
  logic [14:0] width_gain;

  logic               en;
  item_t              entry;
  item_t              st [NST];
  logic signed [16:0] nx;
  logic signed [16:0] ny;
  logic signed [16:0] nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_is_y         <= 1'b0;
      normals_present <= 1'b0;
      scale_enable    <= 1'b0;
      width_gain      <= SCALE_MUL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UP_IS_Y:   up_is_y         <= cfg_wdata[0];
        REG_NORMALS:   normals_present <= cfg_wdata[0];
        REG_SCALE_EN:  scale_enable    <= cfg_wdata[0];
        REG_SCALE_MUL: width_gain      <= cfg_wdata;
      endcase
    end
  end

  assign in_stall = st[NST-1].vld & out_stall;
  assign en       = ~in_stall;

  assign nx = {normal_x[15], normal_x};
  assign ny = {normal_y[15], normal_y};
  assign nz = {normal_z[15], normal_z};

  always_comb begin
    entry     = '0;
    entry.vld = in_valid;
    entry.px  = pos_x;
    entry.py  = pos_y;
    entry.pz  = pos_z;
    entry.upy = up_is_y;
    entry.u   = up_is_y ? ny : nz;
    entry.ca  = up_is_y ? nz : 17'(-ny);
    entry.cb  = up_is_y ? 17'(-nx) : nx;
    entry.neg = entry.u[16];
    entry.ov  = normals_present && ((normal_x | normal_y | normal_z) != '0);
    entry.sc  = scale_enable ? 31'(width) * 31'(width_gain) : 31'd0;
    entry.scv = scale_enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) begin
        st[k].vld <= 1'b0;
      end
    end else if (en) begin
      st[0] <= entry;
      for (int k = 1; k < NST; k++) begin
        st[k] <= stage_step(k, st[k-1]);
      end
    end
  end

  assign out_valid         = st[NST-1].vld;
  assign out_pos_x         = st[NST-1].px;
  assign out_pos_y         = st[NST-1].py;
  assign out_pos_z         = st[NST-1].pz;
  assign quat_w            = st[NST-1].fw;
  assign quat_x            = st[NST-1].fx;
  assign quat_y            = st[NST-1].fy;
  assign quat_z            = st[NST-1].fz;
  assign orientation_valid = st[NST-1].ov;
  assign scale_out         = st[NST-1].sc;
  assign scale_valid       = st[NST-1].scv;

endmodule

[sim/tb_normal_to_quaternion_instancer.sv]
// Self-checking testbench for the normal-to-quaternion point instancer.
`timescale 1ns / 1ps

module tb_normal_to_quaternion_instancer;
  import nqi_pkg::*;

  localparam int LATENCY = 167;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] qw;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
    logic        ov;
    logic [30:0] sc;
    logic        scv;
  } instance_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic        [1:0]  cfg_index = '0;
  logic        [14:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic signed [15:0] normal_x = '0;
  logic signed [15:0] normal_y = '0;
  logic signed [15:0] normal_z = '0;
  logic        [15:0] width = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               orientation_valid;
  logic        [30:0] scale_out;
  logic               scale_valid;

  normal_to_quaternion_instancer DUT (.*);

  always #2 clk = ~clk;

  logic        up_y_cfg = 1'b0;
  logic        normals_cfg = 1'b0;
  logic        scale_en_cfg = 1'b0;
  logic [14:0] multiplier_cfg = SCALE_MUL_RESET;

  instance_t instance_q[$];
  int errors = 0;
  int points_sent = 0;
  int instances_checked = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int in_gap_left = 0;
  int stall_left = 0;
  int free_left = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint axis_part(input longint c, input longint unsigned n);
    longint unsigned mag;
    longint s;
    mag = longint'(c < 0 ? -c : c) << 29;
    s = longint'((2 * mag + n) / (2 * n));
    return clamp_unit(c < 0 ? -s : s);
  endfunction

  function automatic instance_t orient_point(input logic [31:0] px, input logic [31:0] py,
                                             input logic [31:0] pz, input logic [15:0] sx,
                                             input logic [15:0] sy, input logic [15:0] sz,
                                             input logic [15:0] w);
    instance_t r;
    longint nx, ny, nz, u, c0, c1, c2;
    longint unsigned p2, l2, lq, au, a, nn;
    longint q0, q1, q2, q3;
    bit near;
    nx = longint'($signed(sx));
    ny = longint'($signed(sy));
    nz = longint'($signed(sz));
    q0 = 16384; q1 = 0; q2 = 0; q3 = 0;
    r.ov = 1'b0;
    if (normals_cfg && (nx != 0 || ny != 0 || nz != 0)) begin
      if (up_y_cfg) begin
        u = ny; c0 = nz; c1 = 0; c2 = -nx;
        p2 = nx * nx + nz * nz;
      end else begin
        u = nz; c0 = -ny; c1 = nx; c2 = 0;
        p2 = nx * nx + ny * ny;
      end
      l2 = p2 + u * u;
      r.ov = 1'b1;
      near = 1'b0;
      if (u != 0 && p2 < (64'd1 << 21))
        near = p2 * 64'd1000000000000 < 64'd1999999 * l2;
      if (near && u > 0) begin
      end else if (near) begin
        q0 = 0; q1 = 16384;
      end else begin
        lq = int_sqrt(l2 << 30);
        au = longint'(u < 0 ? -u : u) << 15;
        if (u >= 0) a = lq + au;
        else a = (p2 << 30) / (lq + au);
        if (a == 0) a = 1;
        q0 = clamp_unit(longint'((int_sqrt((a << 29) / lq) + 1) >> 1));
        nn = int_sqrt(2 * lq * a);
        if (nn == 0) nn = 1;
        q1 = axis_part(c0, nn);
        q2 = axis_part(c1, nn);
        q3 = axis_part(c2, nn);
      end
    end
    r.px = px; r.py = py; r.pz = pz;
    r.qw = q0[15:0]; r.qx = q1[15:0]; r.qy = q2[15:0]; r.qz = q3[15:0];
    r.scv = scale_en_cfg;
    r.sc = scale_en_cfg ? 31'(32'(w) * 32'(multiplier_cfg)) : 31'd0;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    errors++;
    $display("Mismatch on result %0d, %s: got %0h, expected %0h",
             instances_checked, field, got, want);
  endtask

  always @(posedge clk) begin
    instance_t e;
    if (!rst && out_valid && !out_stall) begin
      if (instance_q.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        e = instance_q.pop_front();
        if (out_pos_x !== e.px) report_mismatch("out_pos_x", out_pos_x, e.px);
        if (out_pos_y !== e.py) report_mismatch("out_pos_y", out_pos_y, e.py);
        if (out_pos_z !== e.pz) report_mismatch("out_pos_z", out_pos_z, e.pz);
        if (quat_w !== e.qw) report_mismatch("quat_w", quat_w, e.qw);
        if (quat_x !== e.qx) report_mismatch("quat_x", quat_x, e.qx);
        if (quat_y !== e.qy) report_mismatch("quat_y", quat_y, e.qy);
        if (quat_z !== e.qz) report_mismatch("quat_z", quat_z, e.qz);
        if (orientation_valid !== e.ov)
          report_mismatch("orientation_valid", orientation_valid, e.ov);
        if (scale_out !== e.sc) report_mismatch("scale_out", scale_out, e.sc);
        if (scale_valid !== e.scv) report_mismatch("scale_valid", scale_valid, e.scv);
      end
      instances_checked++;
    end
  end

  // Receiver stalls in bursts, separated by free stretches of random length.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) begin
        out_stall <= 1'b0;
        free_left = $urandom_range(1, 60);
      end
    end else if (free_left > 0) begin
      free_left--;
    end else begin
      stall_left = $urandom_range(1, 16);
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_UP_IS_Y:   up_y_cfg = val[0];
      REG_NORMALS:   normals_cfg = val[0];
      REG_SCALE_EN:  scale_en_cfg = val[0];
      REG_SCALE_MUL: multiplier_cfg = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input bit upy, input bit nrm, input bit sen, input logic [14:0] mul);
    write_reg(REG_UP_IS_Y, {14'd0, upy});
    write_reg(REG_NORMALS, {14'd0, nrm});
    write_reg(REG_SCALE_EN, {14'd0, sen});
    write_reg(REG_SCALE_MUL, mul);
  endtask

  task automatic send_point(input logic [15:0] sx, input logic [15:0] sy,
                            input logic [15:0] sz, input logic [15:0] w);
    logic [31:0] px, py, pz;
    px = $urandom; py = $urandom; pz = $urandom;
    if (!calm && in_gap_left == 0 && $urandom_range(0, 9) == 0)
      in_gap_left = $urandom_range(1, 16);
    if (in_gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (in_gap_left) @(posedge clk);
      in_gap_left = 0;
    end
    in_valid <= 1'b1;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    normal_x <= sx; normal_y <= sy; normal_z <= sz;
    width <= w;
    do @(posedge clk); while (in_stall);
    instance_q.insert(instance_q.size(), orient_point(px, py, pz, sx, sy, sz, w));
    points_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (instance_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic logic [15:0] random_component(input int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 7)) - 16'd3;
      2: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  task automatic send_random_point();
    logic [15:0] n[3];
    int axis, kind;
    kind = $urandom_range(0, 9);
    axis = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) n[i] = 16'($urandom);
    if (kind < 3) begin
      // Nearly aligned with one axis, tiny off-axis parts.
      for (int i = 0; i < 3; i++) n[i] = random_component(1);
      n[axis] = random_component($urandom_range(0, 1) != 0 ? 0 : 3);
    end else if (kind < 5) begin
      for (int i = 0; i < 3; i++) n[i] = random_component(2);
    end else if (kind == 5) begin
      n[$urandom_range(0, 2)] = 16'd0;
      n[axis] = random_component(3);
    end else if (kind == 6 && $urandom_range(0, 3) == 0) begin
      n[0] = 16'd0; n[1] = 16'd0; n[2] = 16'd0;
    end
    send_point(n[0], n[1], n[2], 16'($urandom));
  endtask

  task automatic test_defaults();
    send_point(16'h4000, 16'h0000, 16'h0000, 16'hffff);
    send_point(16'h1234, 16'h8000, 16'h7fff, 16'h0001);
    drain();
  endtask

  task automatic test_z_up();
    configure(1'b0, 1'b1, 1'b1, 15'd25600);
    send_point(16'h0000, 16'h0000, 16'h4000, 16'hffff);
    send_point(16'h0000, 16'h0000, 16'hc000, 16'h0000);
    send_point(16'h0001, 16'h0000, 16'h7fff, 16'h0100);
    send_point(16'h0000, 16'h0001, 16'h8000, 16'h0100);
    send_point(16'h0000, 16'h0000, 16'h0000, 16'h1234);
    send_point(16'h4000, 16'h0000, 16'h0000, 16'h8000);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'hffff);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send_point(16'h8000, 16'h7fff, 16'hc000, 16'h0001);
    send_point(16'h0100, 16'hff00, 16'hfff0, 16'h00ff);
    drain();
  endtask

  task automatic test_y_up();
    configure(1'b1, 1'b1, 1'b1, 15'd3);
    send_point(16'h0000, 16'h4000, 16'h0000, 16'hffff);
    send_point(16'h0000, 16'h8000, 16'h0000, 16'h0001);
    send_point(16'h0000, 16'h0000, 16'h7fff, 16'h0100);
    send_point(16'h8000, 16'h0001, 16'h7fff, 16'h0100);
    send_point(16'h2000, 16'hd000, 16'h1000, 16'h4000);
    send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain();
  endtask

  task automatic test_scale_extremes();
    configure(1'b0, 1'b0, 1'b1, 15'd0);
    send_point(16'h1000, 16'h0000, 16'h1000, 16'hffff);
    drain();
    configure(1'b0, 1'b1, 1'b1, 15'h7fff);
    send_point(16'h1000, 16'h0000, 16'h1000, 16'hffff);
    send_point(16'h0000, 16'h0000, 16'h0001, 16'h8001);
    drain();
  endtask

  task automatic test_random(input bit upy, input bit nrm, input bit sen,
                             input logic [14:0] mul, input int count);
    configure(upy, nrm, sen, mul);
    for (int i = 0; i < count; i++) send_random_point();
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_z_up();
    test_y_up();
    test_scale_extremes();
    test_random(1'b0, 1'b1, 1'b1, 15'($urandom_range(3, 25600)), 300);
    test_random(1'b1, 1'b1, 1'b0, 15'd256, 300);
    test_random(1'b1, 1'b0, 1'b1, 15'd25600, 100);
    test_random(1'b0, 1'b1, 1'b1, 15'd3, 200);
    calm = 1'b1;
    test_random(1'b1, 1'b1, 1'b1, 15'($urandom), 200);
    $display("Sent %0d points and checked %0d instances over both up axes,", points_sent,
             instances_checked);
    $display("with and without normals and scale, under random source and sink idling.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
src/nqi_pkg.sv
src/normal_to_quaternion_instancer.sv
sim/tb_normal_to_quaternion_instancer.sv
